FILE: hdl/pcd_pkg.sv
// Shared types, widths and helpers for the point to cylinder distance block
`timescale 1ns / 1ps
package pcd_pkg;
	localparam int COORD_W = 24;
	localparam int LEN_W   = 23;
	localparam int DIST_W  = 24;
	localparam int MAG_W   = 24;          // |coord| up to 2^23
	localparam int SQ_W    = 49;          // x^2 + y^2
	localparam int ROOT_W  = 25;          // sqrt of SQ_W bits
	localparam int RSQ_W   = 50;          // q^2-ish sums for the rim root
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 1'd1;
	localparam logic [LEN_W-1:0] LEN_RESET = 23'd65536;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;
	localparam int OUT_DEPTH = 4;         // result queue, a power of two
	localparam int OUT_AW = 2;

	// case codes from the front part
	localparam logic [1:0] CASE_INSIDE = 2'd0;
	localparam logic [1:0] CASE_CAP    = 2'd1;
	localparam logic [1:0] CASE_RIM    = 2'd2;
	localparam logic [1:0] CASE_SIDE   = 2'd3;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} pcd_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              inside_res;
	} pcd_out_t;

	// classified item passed from front to back
	typedef struct packed {
		logic [1:0]       kind;
		logic [SQ_W-1:0]  sq;
		logic [LEN_W-1:0] r;
		logic [LEN_W:0]   dz;   // |z|-h or h-|z|, both fit 24 bits
	} pcd_job_t;

	typedef struct packed {
		logic [RSQ_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} pcd_sqrt_t;

	// one restoring square-root step: brings two more radicand bits
	function automatic pcd_sqrt_t sqrt_step(input pcd_sqrt_t s, input logic [1:0] bits);
		logic [RSQ_W-1:0] trial;
		logic [RSQ_W-1:0] rem2;
		pcd_sqrt_t        o;
		rem2  = {s.rem[RSQ_W-3:0], bits};
		trial = {{(RSQ_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
		if (rem2 >= trial) begin
			o.rem  = rem2 - trial;
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = rem2;
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction
endpackage

FILE: hdl/point_cylinder_distance_top.sv
// Top level of the point to finite cylinder distance block
// Usage:
//  Input side is a queue: drive point_in and push; a transaction is taken
//  on a rising edge with push high and full low.
//  Result side is a queue: while empty is low result holds the oldest
//  distance and inside flag; pop takes it.
//  Configuration: cfg_we with cfg_index (0 radius, 1 half length) and
//  cfg_data writes a register at once; write only while the block is idle.
//  Path from the accepting edge until empty falls: 2 front
//  stages, the middle queue hop, a 25-stage root for the planar radius,
//  2 difference and square stages, a 25-stage root for the rim distance,
//  the result queue write.
//  Throughput: one point per cycle while the result side keeps popping.
//  Reset (arst_n low) empties both queues and sets radius and half length
//  to 1.0. When the receiver stalls and the 4-entry result queue is full,
//  the back pipeline holds, the middle queue fills, the front pipeline
//  stalls, and full rises; no transaction is lost.
`timescale 1ns / 1ps
module point_cylinder_distance_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcd_pkg::LEN_W-1:0]     cfg_data,
	input  logic                          push,
	output logic                          full,
	input  pcd_pkg::pcd_in_t              point_in,
	output logic                          empty,
	input  logic                          pop,
	output pcd_pkg::pcd_out_t             result
);
	logic              job_valid, take, advance, qne;
	logic [pcd_pkg::QUEUE_AW:0] cnt;
	pcd_pkg::pcd_job_t job, qjob;

	// front stalls only when the middle queue cannot absorb its two stages
	assign advance = cnt < 3'(pcd_pkg::QUEUE_DEPTH - 2) || take;
	assign full    = !advance;

	pcd_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(push && !full), .in_item(point_in), .advance,
		.job_valid, .job
	);

	pcd_queue u_queue (
		.clk, .arst_n, .wr(job_valid && advance), .wr_data(job),
		.rd(take), .not_empty(qne), .count(cnt), .rd_data(qjob)
	);

	pcd_back u_back (
		.clk, .arst_n, .job_valid(qne), .job(qjob), .take,
		.pop, .empty, .result
	);
endmodule

FILE: hdl/pcd_front.sv
// Front part: register writes, magnitudes, squares and case classification
`timescale 1ns / 1ps
module pcd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pcd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcd_pkg::LEN_W-1:0]         cfg_data,
	input  logic                              in_valid,
	input  pcd_pkg::pcd_in_t                  in_item,
	input  logic                              advance,
	output logic                              job_valid,
	output pcd_pkg::pcd_job_t                 job
);
	logic [pcd_pkg::LEN_W-1:0] radius_q, half_q;
	logic [pcd_pkg::MAG_W-1:0] ax, ay, az;
	logic [pcd_pkg::MAG_W-1:0] ax_s1, ay_s1, az_s1;
	logic                      v_s1, v_s2;
	logic [47:0]               xx_s2, yy_s2;
	logic [45:0]               rr_s2;
	logic [pcd_pkg::MAG_W-1:0] az_s2;
	logic [pcd_pkg::LEN_W-1:0] r_s1, h_s1, r_s2, h_s2;
	logic [pcd_pkg::SQ_W-1:0]  sq;
	logic [pcd_pkg::SQ_W-1:0]  rsq;
	logic                      in_rad, on_rad, in_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= pcd_pkg::LEN_RESET;
			half_q   <= pcd_pkg::LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pcd_pkg::REG_RADIUS:      radius_q <= cfg_data;
				pcd_pkg::REG_HALF_LENGTH: half_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [pcd_pkg::MAG_W-1:0] mag(
		input logic signed [pcd_pkg::COORD_W-1:0] v);
		return v[pcd_pkg::COORD_W-1] ? pcd_pkg::MAG_W'(-v) : pcd_pkg::MAG_W'(v);
	endfunction

	assign ax = mag(in_item.point_x);
	assign ay = mag(in_item.point_y);
	assign az = mag(in_item.point_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ax_s1 <= ax; ay_s1 <= ay; az_s1 <= az;
			r_s1 <= radius_q; h_s1 <= half_q;
			xx_s2 <= ax_s1 * ax_s1;
			yy_s2 <= ay_s1 * ay_s1;
			rr_s2 <= r_s1 * r_s1;
			az_s2 <= az_s1; r_s2 <= r_s1; h_s2 <= h_s1;
		end
	end

	assign sq     = {1'b0, xx_s2} + {1'b0, yy_s2};
	assign rsq    = {3'b0, rr_s2};
	assign in_rad = sq < rsq;
	assign on_rad = sq <= rsq;
	assign in_len = az_s2 <= {1'b0, h_s2};

	always_comb begin
		job.sq = sq;
		job.r  = r_s2;
		if (on_rad && in_len) begin
			job.kind = pcd_pkg::CASE_INSIDE;
			job.dz   = {1'b0, h_s2} - az_s2;
		end else if (!in_len || az_s2 == {1'b0, h_s2}) begin
			job.dz   = az_s2 - {1'b0, h_s2};
			job.kind = in_rad ? pcd_pkg::CASE_CAP : pcd_pkg::CASE_RIM;
		end else begin
			job.kind = pcd_pkg::CASE_SIDE;
			job.dz   = {1'b0, h_s2} - az_s2;
		end
	end
	assign job_valid = v_s2;
endmodule

FILE: hdl/pcd_queue.sv
// Short queue of classified items between the front and back parts
`timescale 1ns / 1ps
module pcd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  pcd_pkg::pcd_job_t wr_data,
	input  logic              rd,
	output logic              not_empty,
	output logic [pcd_pkg::QUEUE_AW:0] count,
	output pcd_pkg::pcd_job_t rd_data
);
	pcd_pkg::pcd_job_t mem_q [pcd_pkg::QUEUE_DEPTH];
	logic [pcd_pkg::QUEUE_AW-1:0] wp_q, rp_q;
	logic [pcd_pkg::QUEUE_AW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{pcd_pkg::QUEUE_AW{1'b0}}, wr} - {{pcd_pkg::QUEUE_AW{1'b0}}, rd};
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
	assign rd_data   = mem_q[rp_q];
	assign not_empty = cnt_q != '0;
	assign count     = cnt_q;
endmodule

FILE: hdl/pcd_back.sv
// Back part: pipelined square roots, distance selection and result queue
`timescale 1ns / 1ps
module pcd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  pcd_pkg::pcd_job_t job,
	output logic              take,
	input  logic              pop,
	output logic              empty,
	output pcd_pkg::pcd_out_t result
);
	localparam int NQ = 25;   // root steps for q, two radicand bits each
	localparam int NR = 25;   // root steps for the rim distance

	typedef struct packed {
		logic [1:0]                kind;
		logic [pcd_pkg::SQ_W-1:0]  sq;
		logic [pcd_pkg::LEN_W-1:0] r;
		logic [pcd_pkg::LEN_W:0]   dz;
	} meta_t;

	pcd_pkg::pcd_sqrt_t qs  [NQ+1];
	meta_t              qm  [NQ+1];
	logic [NQ:0]        qv;
	logic               go;

	// result queue
	pcd_pkg::pcd_out_t           oq_q [pcd_pkg::OUT_DEPTH];
	logic [pcd_pkg::OUT_AW-1:0]  owp_q, orp_q;
	logic [pcd_pkg::OUT_AW:0]    ocnt_q;
	logic                        out_wr, out_rd;

	assign out_rd = pop && !empty;
	// hold the whole pipeline while the result queue is full and not popped
	assign go     = !ocnt_q[pcd_pkg::OUT_AW] || out_rd;
	assign take   = job_valid && go;

	always_comb begin
		qs[0].rem  = '0;
		qs[0].root = '0;
		qm[0] = meta_t'{job.kind, job.sq, job.r, job.dz};
	end
	assign qv[0] = take;

	// q = floor(sqrt(sq)): one step a stage
	for (genvar i = 0; i < NQ; i++) begin : g_q
		pcd_pkg::pcd_sqrt_t s_s;
		meta_t              m_s;
		logic               v_s;
		logic [1:0]         b;
		always_comb begin
			b = (2*(NQ-1-i)+1 < pcd_pkg::SQ_W) ?
				{qm[i].sq[(2*(NQ-1-i)+1) % pcd_pkg::SQ_W], qm[i].sq[2*(NQ-1-i)]} :
				{1'b0, qm[i].sq[2*(NQ-1-i)]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)  v_s <= 1'b0;
			else if (go)  v_s <= qv[i];
		end
		always_ff @(posedge clk) begin
			if (go) begin
				s_s <= pcd_pkg::sqrt_step(qs[i], b);
				m_s <= qm[i];
			end
		end
		assign qs[i+1] = s_s;
		assign qm[i+1] = m_s;
		assign qv[i+1] = v_s;
	end

	// diff stage, then square stage
	logic [pcd_pkg::ROOT_W-1:0] q_w;
	logic [pcd_pkg::ROOT_W-1:0] dq_s1, dd_s1;
	logic [1:0]                 k_s1, k_s2;
	logic [pcd_pkg::ROOT_W-1:0] dq_s2, dd_s2;
	logic [pcd_pkg::RSQ_W-1:0]  sum_s2;
	logic [pcd_pkg::RSQ_W-1:0]  dq_sq_w, dd_sq_w;
	logic                       v_a, v_b;
	logic [pcd_pkg::ROOT_W-1:0] side_w, cap_w;

	assign q_w    = qs[NQ].root;
	assign side_w = {2'b0, qm[NQ].r} - q_w;
	assign cap_w  = {1'b0, qm[NQ].dz};
	assign dq_sq_w = dq_s1 * dq_s1;
	assign dd_sq_w = dd_s1 * dd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin v_a <= 1'b0; v_b <= 1'b0; end
		else if (go) begin v_a <= qv[NQ]; v_b <= v_a; end
	end
	always_ff @(posedge clk) begin
		if (go) begin
			k_s1 <= qm[NQ].kind;
			dd_s1 <= cap_w;
			case (qm[NQ].kind)
				pcd_pkg::CASE_INSIDE: dq_s1 <= (side_w < cap_w) ? side_w : cap_w;
				pcd_pkg::CASE_CAP:    dq_s1 <= cap_w;
				default:              dq_s1 <= q_w - {2'b0, qm[NQ].r};
			endcase
			k_s2  <= k_s1;
			dq_s2 <= dq_s1;
			dd_s2 <= dd_s1;
			sum_s2 <= dq_sq_w + dd_sq_w;
		end
	end

	// rim root pipeline
	pcd_pkg::pcd_sqrt_t rs [NR+1];
	logic [pcd_pkg::RSQ_W-1:0]  rsum [NR+1];
	logic [pcd_pkg::ROOT_W-1:0] rdq  [NR+1];
	logic [1:0]                 rk   [NR+1];
	logic [NR:0]                rv;
	assign rs[0].rem = '0; assign rs[0].root = '0;
	assign rsum[0] = sum_s2; assign rdq[0] = dq_s2; assign rk[0] = k_s2; assign rv[0] = v_b;

	for (genvar j = 0; j < NR; j++) begin : g_r
		pcd_pkg::pcd_sqrt_t s_s;
		logic [pcd_pkg::RSQ_W-1:0]  u_s;
		logic [pcd_pkg::ROOT_W-1:0] d_s;
		logic [1:0]                 k_s;
		logic                       v_s;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)  v_s <= 1'b0;
			else if (go)  v_s <= rv[j];
		end
		always_ff @(posedge clk) begin
			if (go) begin
				s_s <= pcd_pkg::sqrt_step(rs[j], rsum[j][2*(NR-1-j) +: 2]);
				u_s <= rsum[j]; d_s <= rdq[j]; k_s <= rk[j];
			end
		end
		assign rs[j+1] = s_s; assign rsum[j+1] = u_s;
		assign rdq[j+1] = d_s; assign rk[j+1] = k_s; assign rv[j+1] = v_s;
	end

	logic [pcd_pkg::ROOT_W-1:0] dist_w;
	pcd_pkg::pcd_out_t          res_w;
	assign dist_w = (rk[NR] == pcd_pkg::CASE_RIM) ? rs[NR].root : rdq[NR];
	assign res_w.distance   = dist_w[pcd_pkg::ROOT_W-1] ? pcd_pkg::DIST_MAX
		: dist_w[pcd_pkg::DIST_W-1:0];
	assign res_w.inside_res = rk[NR] == pcd_pkg::CASE_INSIDE;
	assign out_wr = rv[NR] && go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= '0; orp_q <= '0; ocnt_q <= '0;
		end else begin
			if (out_wr) owp_q <= owp_q + 1'b1;
			if (out_rd) orp_q <= orp_q + 1'b1;
			ocnt_q <= ocnt_q + {{pcd_pkg::OUT_AW{1'b0}}, out_wr}
				- {{pcd_pkg::OUT_AW{1'b0}}, out_rd};
		end
	end
	always_ff @(posedge clk) begin
		if (out_wr) oq_q[owp_q] <= res_w;
	end
	assign result = oq_q[orp_q];
	assign empty  = ocnt_q == '0;
endmodule

FILE: tb/tb_point_cylinder_distance_top.sv
// Testbench for the point to finite cylinder distance block
`timescale 1ns / 1ps
module tb_point_cylinder_distance_top;

	class distance_scoreboard;
		logic [pcd_pkg::LEN_W-1:0] radius_q;
		logic [pcd_pkg::LEN_W-1:0] half_len_q;
		pcd_pkg::pcd_out_t expected_q[$];
		int errors;

		function void reset_regs();
			radius_q = pcd_pkg::LEN_RESET;
			half_len_q = pcd_pkg::LEN_RESET;
		endfunction

		function void set_reg(logic [pcd_pkg::CFG_IDX_W-1:0] idx,
			logic [pcd_pkg::LEN_W-1:0] val);
			if (idx == pcd_pkg::REG_RADIUS)
				radius_q = val;
			else if (idx == pcd_pkg::REG_HALF_LENGTH)
				half_len_q = val;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		function logic [63:0] floor_root(logic [63:0] v);
			logic [63:0] res;
			logic [63:0] b;
			res = '0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else
					res = res >> 1;
				b = b >> 2;
			end
			return res;
		endfunction

		function logic [63:0] mag(logic signed [pcd_pkg::COORD_W-1:0] c);
			logic signed [63:0] w;
			w = 64'(c);
			return (w < 0) ? -w : w;
		endfunction

		function void note_point(pcd_pkg::pcd_in_t p);
			logic [63:0] ax, ay, az, r, h, sq, rsq, q, dst, side, cap;
			pcd_pkg::pcd_out_t o;
			ax = mag(p.point_x);
			ay = mag(p.point_y);
			az = mag(p.point_z);
			r = 64'(radius_q);
			h = 64'(half_len_q);
			sq = ax * ax + ay * ay;
			rsq = r * r;
			q = floor_root(sq);
			o.inside_res = 1'b0;
			if (sq <= rsq && az <= h) begin
				side = r - q;
				cap = h - az;
				dst = (side < cap) ? side : cap;
				o.inside_res = 1'b1;
			end else if (az >= h) begin
				if (sq < rsq)
					dst = az - h;
				else
					dst = floor_root((q - r) * (q - r) + (az - h) * (az - h));
			end else
				dst = q - r;
			if (dst > 64'hFF_FFFF)
				dst = 64'hFF_FFFF;
			o.distance = dst[pcd_pkg::DIST_W-1:0];
			expected_q.push_back(o);
		endfunction

		task check_result(pcd_pkg::pcd_out_t got);
			pcd_pkg::pcd_out_t exp_r;
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing expected");
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.distance !== exp_r.distance)
				report_mismatch($sformatf("distance got %0d want %0d",
					got.distance, exp_r.distance));
			if (got.inside_res !== exp_r.inside_res)
				report_mismatch($sformatf("inside got %0b want %0b",
					got.inside_res, exp_r.inside_res));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pcd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pcd_pkg::LEN_W-1:0] cfg_data;
	logic push;
	logic full;
	pcd_pkg::pcd_in_t point_in;
	logic empty;
	logic pop;
	pcd_pkg::pcd_out_t result;
	distance_scoreboard sb;
	int pop_mode;

	point_cylinder_distance_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .push(push), .full(full), .point_in(point_in),
		.empty(empty), .pop(pop), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: accept and check; stall on its own pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result(result);
			case (pop_mode)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 3) != 0);
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= ($urandom_range(0, 19) == 0);
			endcase
		end
	end

	// hold push high until the transaction is taken; the caller lowers it
	task automatic send_point(pcd_pkg::pcd_in_t p);
		push <= 1'b1;
		point_in <= p;
		do @(posedge clk); while (full);
		sb.note_point(p);
	endtask

	task automatic idle(int n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_results();
		push <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	task automatic drain();
		wait_results();
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [pcd_pkg::CFG_IDX_W-1:0] idx,
		logic [pcd_pkg::LEN_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [pcd_pkg::COORD_W-1:0] rand_coord(int lim);
		logic signed [pcd_pkg::COORD_W-1:0] c;
		case ($urandom_range(0, 5))
			0: c = pcd_pkg::COORD_W'($urandom);
			1: c = $urandom_range(0, 1) ? 24'sh7F_FFFF : 24'sh80_0000;
			default: begin
				c = pcd_pkg::COORD_W'($urandom_range(0, lim));
				if ($urandom_range(0, 1))
					c = -c;
			end
		endcase
		return c;
	endfunction

	function automatic pcd_pkg::pcd_in_t mk(int x, int y, int z);
		pcd_pkg::pcd_in_t p;
		p.point_x = pcd_pkg::COORD_W'(x);
		p.point_y = pcd_pkg::COORD_W'(y);
		p.point_z = pcd_pkg::COORD_W'(z);
		return p;
	endfunction

	initial begin
		logic [pcd_pkg::LEN_W-1:0] rads[4];
		logic [pcd_pkg::LEN_W-1:0] lens[4];
		int lim, n;
		sb = new();
		sb.reset_regs();
		pop_mode = 1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pcd_pkg::REG_RADIUS;
		cfg_data = '0;
		push = 1'b0;
		point_in = '0;
		pop = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, then extremes
		send_point(mk(0, 0, 0));
		send_point(mk(65536, 0, 0));
		send_point(mk(0, 65536, 65536));
		send_point(mk(0, 0, 131072));
		send_point(mk(200000, 0, 200000));
		send_point(mk(200000, 10, 0));
		send_point(mk(30000, 30000, 10000));
		send_point(mk(46341, 46341, 0));
		send_point(mk(8388607, 8388607, 8388607));
		send_point(mk(-8388608, -8388608, -8388608));
		send_point(mk(-8388608, 0, 0));
		send_point(mk(-1, -1, -1));
		send_point(mk(0, 0, -65536));
		send_point(mk(-65536, 0, -65536));
		drain();
		write_reg(pcd_pkg::REG_RADIUS, '0);
		write_reg(pcd_pkg::REG_HALF_LENGTH, '0);
		send_point(mk(0, 0, 0));
		send_point(mk(1, 0, 0));
		send_point(mk(0, 0, -1));
		send_point(mk(-8388608, -8388608, -8388608));
		drain();
		write_reg(pcd_pkg::REG_RADIUS, 23'h7F_FFFF);
		write_reg(pcd_pkg::REG_HALF_LENGTH, 23'h7F_FFFF);
		send_point(mk(8388607, 0, 8388607));
		send_point(mk(-8388608, -8388608, -8388608));
		send_point(mk(5000000, 6000000, 100));
		send_point(mk(0, 0, 0));
		drain();

		rads = '{23'd65536, 23'd0, 23'h7F_FFFF, 23'd300};
		lens = '{23'd65536, 23'h7F_FFFF, 23'd0, 23'd500};
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 4) begin
				write_reg(pcd_pkg::REG_RADIUS, rads[ph]);
				write_reg(pcd_pkg::REG_HALF_LENGTH, lens[ph]);
			end else begin
				write_reg(pcd_pkg::REG_RADIUS, pcd_pkg::LEN_W'($urandom));
				write_reg(pcd_pkg::REG_HALF_LENGTH, pcd_pkg::LEN_W'($urandom));
			end
			lim = (sb.radius_q > sb.half_len_q ? sb.radius_q : sb.half_len_q) * 2 + 16;
			if (lim > 8388607)
				lim = 8388607;
			pop_mode = ph % 4;
			n = 0;
			while (n < 170) begin
				int blen;
				blen = $urandom_range(1, 12);
				for (int i = 0; i < blen; i++) begin
					send_point(mk(rand_coord(lim), rand_coord(lim), rand_coord(lim)));
					n++;
				end
				if ($urandom_range(0, 2) != 0)
					idle($urandom_range(1, 8));
				if (n > 80 && n < 93)
					wait_results();
			end
			pop_mode = 0;
			drain();
		end

		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
